// ===== rtl/nearest_point_table_assert.svh =====
// Assertion macros for the nearest point table controller.
`ifndef NEAREST_POINT_TABLE_ASSERT_SVH
`define NEAREST_POINT_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define NPT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nearest_point_table: same-cycle check failed");
`define NPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nearest_point_table: next-cycle check failed");
`else
`define NPT_ASSERT_IMP(label, clk, rst, ante, cons)
`define NPT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/npt_pkg.sv =====
// Types and constants of the nearest point table.
package npt_pkg;

   localparam int SLOT_BITS   = 6;
   localparam int COORD_BITS  = 16;
   localparam int SQ_BITS     = 33;
   localparam int COUNT_BITS  = 7;
   localparam int STATUS_BITS = 2;
   localparam int MODE_BITS   = 2;

   localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_MOVE   = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_QUERY  = 2'd3;

   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd3;

   localparam logic [SQ_BITS-1:0] SQ_MAX = 33'd8589672450;

   typedef struct packed {
      logic load;
      logic add_wr;
      logic move_rd;
      logic move_wr;
      logic rem_start;
      logic q_start;
      logic scan_rd;
      logic shift_wr;
      logic count_dec;
      logic diff_en;
      logic sq_en;
      logic best_en;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic                 full;
      logic                 slot_bad;
      logic                 empty;
      logic                 more;
   } stat_type;

endpackage

// ===== rtl/nearest_point_table.sv =====
// Top level of the nearest point table: controller and datapath.
// An item is taken when start is high and busy is low; its single result appears one cycle
// on the rsp_ ports with rsp_valid high and must be taken then, as the receiver cannot stall.
// Add writes in the decode state and move reads its slot there and writes it in S_MOVE_WR;
// remove and query walk the point memory through its single read port, one entry per cycle,
// remove shifting each later entry down one slot and query passing each entry through the read,
// difference, square and compare stages of the distance pipeline. busy falls in the cycle the
// result is shown, so the next item can enter then.
module nearest_point_table import npt_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [MODE_BITS-1:0]          req_mode,
   input  logic [SLOT_BITS-1:0]          req_slot,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   output logic                          rsp_valid,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic [SLOT_BITS-1:0]          rsp_result_index,
   output logic [SQ_BITS-1:0]            rsp_sq_distance,
   output logic [COUNT_BITS-1:0]         rsp_point_count
);

   cmd_type  cmd;
   stat_type stat;

   npt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .stat      (stat),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

   npt_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_slot         (req_slot),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_sq_distance  (rsp_sq_distance),
      .rsp_point_count  (rsp_point_count)
   );

endmodule

// ===== rtl/npt_datapath.sv =====
// Datapath of the nearest point table: point memory, count, distance pipeline, results.
module npt_datapath import npt_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output stat_type                      stat,
   input  logic [MODE_BITS-1:0]          req_mode,
   input  logic [SLOT_BITS-1:0]          req_slot,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic [SLOT_BITS-1:0]          rsp_result_index,
   output logic [SQ_BITS-1:0]            rsp_sq_distance,
   output logic [COUNT_BITS-1:0]         rsp_point_count
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int SW = (CW > SLOT_BITS) ? CW : SLOT_BITS;
   localparam int RW = (AW > SLOT_BITS) ? AW : SLOT_BITS;
   localparam int PW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
   localparam int EW = 2 * COORD_BITS;

   function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] s;
      s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
      if (s[COORD_BITS] != s[COORD_BITS-1]) begin
         return s[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                              : {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return s[COORD_BITS-1:0];
   endfunction

   logic [MODE_BITS-1:0]   mode_ff;
   logic [SLOT_BITS-1:0]   slot_ff;
   logic [COORD_BITS-1:0]  cx_ff;
   logic [COORD_BITS-1:0]  cy_ff;

   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;

   logic [EW-1:0]          mem_ff [MAX_POINTS];
   logic [EW-1:0]          rdata_ff;
   logic                   we;
   logic [AW-1:0]          wa;
   logic [EW-1:0]          wd;
   logic                   re;
   logic [AW-1:0]          ra;

   logic [CW-1:0]          idx_ff;
   logic [AW-1:0]          waddr_ff;
   logic [AW-1:0]          ridx_ff;
   logic [AW-1:0]          didx_ff;
   logic [AW-1:0]          sidx_ff;

   logic signed [COORD_BITS:0] dx_ff;
   logic signed [COORD_BITS:0] dy_ff;
   logic [EW-1:0]          sqx_ff;
   logic [EW-1:0]          sqy_ff;
   logic [SQ_BITS-1:0]     best_ff;
   logic [AW-1:0]          bidx_ff;
   logic                   found_ff;

   logic [COORD_BITS-1:0]  px_rd;
   logic [COORD_BITS-1:0]  py_rd;
   logic [COORD_BITS:0]    ax_full;
   logic [COORD_BITS:0]    ay_full;
   logic [COORD_BITS-1:0]  ax;
   logic [COORD_BITS-1:0]  ay;
   logic [SQ_BITS-1:0]     sum;

   logic                   full;
   logic [SW-1:0]          slot_ext;
   logic [SW-1:0]          count_ext;

   logic [STATUS_BITS-1:0] status_in;
   logic [RW-1:0]          index_wide;
   logic [SQ_BITS-1:0]     dist_in;
   logic [PW-1:0]          count_wide;

   logic [STATUS_BITS-1:0] status_ff;
   logic [SLOT_BITS-1:0]   index_ff;
   logic [SQ_BITS-1:0]     dist_ff;
   logic [COUNT_BITS-1:0]  pcount_ff;

   assign slot_ext  = SW'(slot_ff);
   assign count_ext = SW'(count_ff);
   assign full      = (count_ff == CW'(MAX_POINTS));

   assign stat.mode     = mode_ff;
   assign stat.full     = full;
   assign stat.slot_bad = (slot_ext >= count_ext);
   assign stat.empty    = (count_ff == '0);
   assign stat.more     = (idx_ff < count_ff);

   assign px_rd = rdata_ff[EW-1:COORD_BITS];
   assign py_rd = rdata_ff[COORD_BITS-1:0];

   always_comb begin
      count_in = count_ff;
      if (cmd.add_wr && !full) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      we = 1'b0;
      wa = waddr_ff;
      wd = rdata_ff;
      if (cmd.add_wr && !full) begin
         we = 1'b1;
         wa = count_ff[AW-1:0];
         wd = {cx_ff, cy_ff};
      end else if (cmd.move_wr) begin
         we = 1'b1;
         wa = AW'(slot_ff);
         wd = {sat_add(px_rd, cx_ff), sat_add(py_rd, cy_ff)};
      end else if (cmd.shift_wr) begin
         we = 1'b1;
      end
   end

   assign re = cmd.move_rd | cmd.scan_rd;
   assign ra = cmd.move_rd ? AW'(slot_ff) : idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      if (re) begin
         rdata_ff <= mem_ff[ra];
      end
   end

   assign ax_full = dx_ff[COORD_BITS] ? (~dx_ff + 1'b1) : dx_ff;
   assign ay_full = dy_ff[COORD_BITS] ? (~dy_ff + 1'b1) : dy_ff;
   assign ax      = ax_full[COORD_BITS-1:0];
   assign ay      = ay_full[COORD_BITS-1:0];
   assign sum     = SQ_BITS'(sqx_ff) + SQ_BITS'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.rem_start) begin
            idx_ff <= CW'(slot_ff) + CW'(1);
         end else if (cmd.q_start) begin
            idx_ff <= '0;
         end else if (cmd.scan_rd) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.q_start) begin
            found_ff <= 1'b0;
         end else if (cmd.best_en) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         slot_ff <= req_slot;
         cx_ff   <= req_coord_x;
         cy_ff   <= req_coord_y;
      end
      if (cmd.rem_start) begin
         waddr_ff <= AW'(slot_ff);
      end else if (cmd.shift_wr) begin
         waddr_ff <= waddr_ff + AW'(1);
      end
      if (cmd.scan_rd) begin
         ridx_ff <= idx_ff[AW-1:0];
      end
      if (cmd.diff_en) begin
         dx_ff   <= $signed({px_rd[COORD_BITS-1], px_rd}) - $signed({cx_ff[COORD_BITS-1], cx_ff});
         dy_ff   <= $signed({py_rd[COORD_BITS-1], py_rd}) - $signed({cy_ff[COORD_BITS-1], cy_ff});
         didx_ff <= ridx_ff;
      end
      if (cmd.sq_en) begin
         sqx_ff  <= ax * ax;
         sqy_ff  <= ay * ay;
         sidx_ff <= didx_ff;
      end
      if (cmd.best_en && (!found_ff || (sum < best_ff))) begin
         best_ff <= sum;
         bidx_ff <= sidx_ff;
      end
   end

   always_comb begin
      status_in  = ST_OK;
      index_wide = '0;
      dist_in    = '0;
      case (mode_ff)
         MODE_ADD: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               index_wide = RW'(count_ff[AW-1:0]);
            end
         end
         MODE_MOVE, MODE_REMOVE: begin
            if (stat.slot_bad) begin
               status_in = ST_RANGE;
            end
         end
         MODE_QUERY: begin
            if (stat.empty) begin
               status_in = ST_EMPTY;
               dist_in   = SQ_MAX;
            end else begin
               index_wide = RW'(bidx_ff);
               dist_in    = best_ff;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign count_wide = PW'(count_in);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff <= status_in;
         index_ff  <= index_wide[SLOT_BITS-1:0];
         dist_ff   <= dist_in;
         pcount_ff <= count_wide[COUNT_BITS-1:0];
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_result_index = index_ff;
   assign rsp_sq_distance  = dist_ff;
   assign rsp_point_count  = pcount_ff;

endmodule

// ===== rtl/npt_controller.sv =====
// Controller of the nearest point table: sequences one item through the datapath.
`include "nearest_point_table_assert.svh"
module npt_controller import npt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     rsp_valid
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_MOVE_WR = 3'd2;
   localparam logic [2:0] S_REMOVE  = 3'd3;
   localparam logic [2:0] S_QUERY   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       v1_ff;
   logic       v2_ff;
   logic       v3_ff;
   logic       rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.load = start;
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.mode)
               MODE_ADD: begin
                  cmd.add_wr = 1'b1;
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
               MODE_MOVE: begin
                  if (stat.slot_bad) begin
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.move_rd = 1'b1;
                     state_in    = S_MOVE_WR;
                  end
               end
               MODE_REMOVE: begin
                  if (stat.slot_bad) begin
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.rem_start = 1'b1;
                     state_in      = S_REMOVE;
                  end
               end
               MODE_QUERY: begin
                  if (stat.empty) begin
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.q_start = 1'b1;
                     state_in    = S_QUERY;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            endcase
         end
         S_MOVE_WR: begin
            cmd.move_wr = 1'b1;
            cmd.finish  = 1'b1;
            state_in    = S_IDLE;
         end
         S_REMOVE: begin
            cmd.scan_rd  = stat.more;
            cmd.shift_wr = v1_ff;
            if (!stat.more && !v1_ff) begin
               cmd.count_dec = 1'b1;
               cmd.finish    = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_QUERY: begin
            cmd.scan_rd = stat.more;
            cmd.diff_en = v1_ff;
            cmd.sq_en   = v2_ff;
            cmd.best_en = v3_ff;
            if (!stat.more && !v1_ff && !v2_ff && !v3_ff) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= cmd.scan_rd;
         v2_ff        <= v1_ff && (state_ff == S_QUERY);
         v3_ff        <= v2_ff;
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `NPT_ASSERT_IMP(a_rsp_at_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE)
   `NPT_ASSERT_NEXT(a_accept_decode, clock, reset, start && (state_ff == S_IDLE), state_ff == S_DECODE)
   `NPT_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff)
   `NPT_ASSERT_IMP(a_query_pipe, clock, reset, cmd.best_en, $past(cmd.sq_en))

endmodule
